[sv/bmcu_pkg.sv]
// shared types, constants and codes for the byte machine control unit
// used by byte_machine_control_unit, bmcu_out_slot and bmcu_checker
package bmcu_pkg;

  // address widths of the data memory and of the io buffer
  localparam int unsigned MEM_ADDR_BITS = 11;
  localparam int unsigned IO_ADDR_BITS  = 5;

  // fixed field widths of the items
  localparam int unsigned AddrW    = 11;
  localparam int unsigned InstrW   = 16;
  localparam int unsigned IoIdxW   = 5;
  localparam int unsigned InTdataW = 24;
  localparam int unsigned InTuserW = 2;
  localparam int unsigned OutTdataW = 72;

  // operand mask for io buffer addressing
  localparam logic [AddrW-1:0] IoMask = AddrW'((64'd1 << IO_ADDR_BITS) - 64'd1);

  // item opcodes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EXEC    = 2'd1,
    OP_RESTART = 2'd2,
    OP_PEEK    = 2'd3
  } op_e;

  // instruction codes in the top five bits of an instruction
  typedef enum logic [4:0] {
    IC_WM  = 5'h01,
    IC_RM  = 5'h02,
    IC_BR  = 5'h03,
    IC_WIO = 5'h05,
    IC_WB  = 5'h06,
    IC_WIB = 5'h07,
    IC_EOP = 5'h1F
  } icode_e;

  // run status
  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_EOP = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH_LO,
    S_DECODE,
    S_FIN
  } fsm_e;

  // one result item
  typedef struct packed {
    logic [7:0]        peek_data;
    logic [7:0]        io_value;
    logic [IoIdxW-1:0] io_index;
    logic              io_write;
    logic [7:0]        io_byte_reg;
    logic [7:0]        buffer_byte;
    logic [InstrW-1:0] instruction;
    logic [AddrW-1:0]  program_counter;
    logic [1:0]        status;
  } result_t;

endpackage

[sv/bmcu_out_slot.sv]
// output register of the byte machine control unit: holds one result item
// until the receiver takes it; uses bmcu_pkg for the result layout
module bmcu_out_slot (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  bmcu_pkg::result_t                   res_i,
  output logic                                free_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bmcu_pkg::OutTdataW-1:0]      m_axis_tdata
);

  localparam int unsigned ResW = $bits(bmcu_pkg::result_t);

  logic              valid_q, valid_d;
  bmcu_pkg::result_t data_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  // pad the packed result up to whole bytes
  assign m_axis_tdata  = {{(bmcu_pkg::OutTdataW - ResW){1'b0}}, data_q};

endmodule

[sv/byte_machine_control_unit.sv]
// top level of the byte machine control unit: sequencer around one
// single-port data memory; uses bmcu_pkg and bmcu_out_slot
//
// usage: s_axis carries one item, tuser the item opcode (load memory byte,
//   execute one instruction, restart, peek memory byte), tdata the address and
//   the data byte. m_axis returns one result item per input item, in order.
// flow: load, peek, restart and execute while halted pass the final step and
//   the output register, and a new item is taken every cycle while the
//   receiver takes results. an execute item uses the single memory port for
//   the high instruction byte, the low byte and the data access in turn; its
//   result then passes the final step and the output register, and the next
//   item is taken only in that final step. RM data is picked up as the result
//   leaves.
// reset: pc, mbr, iobr and the run status clear to zero, the output register
//   empties; the data memory is not cleared and must be loaded before use.
// stall: a finished result waits in the output register; one more item is
//   accepted and worked on, then s_axis_tready stays low until the receiver
//   takes the waiting result.
// io buffer writes are reported on the result item; the buffer itself lives
// with the receiver.
module byte_machine_control_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [10:0] address, [18:11] data, [23:19] zero
  input  logic [bmcu_pkg::InTdataW-1:0]       s_axis_tdata,
  // [1:0] opcode
  input  logic [bmcu_pkg::InTuserW-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [12:2] program_counter, [28:13] instruction,
  // [36:29] buffer_byte, [44:37] io_byte_reg, [45] io_write,
  // [50:46] io_index, [58:51] io_value, [66:59] peek_data, [71:67] zero
  output logic [bmcu_pkg::OutTdataW-1:0]      m_axis_tdata
);

  localparam int unsigned MemW     = bmcu_pkg::MEM_ADDR_BITS;
  localparam int unsigned MemDepth = 1 << MemW;

  // sequencer and architectural registers
  bmcu_pkg::fsm_e    state_q, state_d;
  bmcu_pkg::status_e status_q, status_d;
  logic [MemW-1:0]   pc_q, pc_d;
  logic [7:0]        mbr_q, mbr_d;
  logic [7:0]        iobr_q, iobr_d;

  // per-item registers
  bmcu_pkg::op_e             op_q, op_d;
  logic [7:0]                hi_q, hi_d;
  logic [bmcu_pkg::InstrW-1:0] instr_q, instr_d;
  logic                      rm_q, rm_d;
  logic                      io_wr_q, io_wr_d;
  logic [bmcu_pkg::IoIdxW-1:0] io_idx_q, io_idx_d;
  logic [7:0]                io_val_q, io_val_d;

  // memory port
  logic [7:0]      mem [MemDepth];
  logic            ram_we, ram_re;
  logic [MemW-1:0] ram_addr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata_q;

  // input fields
  bmcu_pkg::op_e   in_op;
  logic [MemW-1:0] in_addr;
  logic [7:0]      in_data;

  // decode of the fetched word
  logic [bmcu_pkg::InstrW-1:0] instr_w;
  logic [4:0]                  code;
  logic [bmcu_pkg::AddrW-1:0]  operand;

  logic              accept;
  logic              out_load;
  logic              out_free;
  bmcu_pkg::result_t res;

  assign in_op   = bmcu_pkg::op_e'(s_axis_tuser[1:0]);
  assign in_addr = s_axis_tdata[MemW-1:0];
  assign in_data = s_axis_tdata[18:11];

  // high byte was captured last cycle, low byte is on the memory output now
  assign instr_w = {hi_q, ram_rdata_q};
  assign code    = instr_w[15:11];
  assign operand = instr_w[10:0];

  // ready when idle, or in the final step once the result can be handed over
  assign s_axis_tready = (state_q == bmcu_pkg::S_IDLE) ||
                         ((state_q == bmcu_pkg::S_FIN) && out_free);

  assign accept = s_axis_tvalid && s_axis_tready;

  // result as it leaves the final step; RM data comes straight off memory
  always_comb begin
    res                 = '0;
    res.status          = status_q;
    res.program_counter = bmcu_pkg::AddrW'(pc_q);
    res.instruction     = instr_q;
    res.buffer_byte     = rm_q ? ram_rdata_q : mbr_q;
    res.io_byte_reg     = iobr_q;
    res.io_write        = io_wr_q;
    res.io_index        = io_idx_q;
    res.io_value        = io_val_q;
    res.peek_data       = (op_q == bmcu_pkg::OP_PEEK) ? ram_rdata_q : 8'd0;
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    pc_d      = pc_q;
    mbr_d     = mbr_q;
    iobr_d    = iobr_q;
    op_d      = op_q;
    hi_d      = hi_q;
    instr_d   = instr_q;
    rm_d      = rm_q;
    io_wr_d   = io_wr_q;
    io_idx_d  = io_idx_q;
    io_val_d  = io_val_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = pc_q;
    ram_wdata = in_data;
    out_load  = 1'b0;

    case (state_q)
      bmcu_pkg::S_IDLE: begin
        state_d = bmcu_pkg::S_IDLE;
      end
      bmcu_pkg::S_FETCH_LO: begin
        // high byte arrives, read the low byte
        ram_re   = 1'b1;
        ram_addr = pc_q;
        hi_d     = ram_rdata_q;
        pc_d     = pc_q + MemW'(1);
        state_d  = bmcu_pkg::S_DECODE;
      end
      bmcu_pkg::S_DECODE: begin
        instr_d = instr_w;
        state_d = bmcu_pkg::S_FIN;
        case (code)
          bmcu_pkg::IC_WB: begin
            mbr_d = operand[7:0];
          end
          bmcu_pkg::IC_WM: begin
            ram_we    = 1'b1;
            ram_addr  = operand[MemW-1:0];
            ram_wdata = mbr_q;
          end
          bmcu_pkg::IC_RM: begin
            ram_re   = 1'b1;
            ram_addr = operand[MemW-1:0];
            rm_d     = 1'b1;
          end
          bmcu_pkg::IC_BR: begin
            pc_d = operand[MemW-1:0];
          end
          bmcu_pkg::IC_WIB: begin
            iobr_d = operand[7:0];
          end
          bmcu_pkg::IC_WIO: begin
            io_wr_d  = 1'b1;
            io_idx_d = bmcu_pkg::IoIdxW'(operand & bmcu_pkg::IoMask);
            io_val_d = iobr_q;
          end
          bmcu_pkg::IC_EOP: begin
            status_d = bmcu_pkg::ST_EOP;
          end
          default: begin
            status_d = bmcu_pkg::ST_BAD;
          end
        endcase
      end
      bmcu_pkg::S_FIN: begin
        // hand the result over and take the next item in the same cycle
        if (out_free) begin
          out_load = 1'b1;
          mbr_d    = res.buffer_byte;
          state_d  = bmcu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bmcu_pkg::S_IDLE;
      end
    endcase

    // a newly accepted item comes after the finishing one
    if (accept) begin
      op_d     = in_op;
      instr_d  = '0;
      rm_d     = 1'b0;
      io_wr_d  = 1'b0;
      io_idx_d = '0;
      io_val_d = '0;
      state_d  = bmcu_pkg::S_FIN;
      case (in_op)
        bmcu_pkg::OP_LOAD: begin
          ram_we    = 1'b1;
          ram_addr  = in_addr;
          ram_wdata = in_data;
        end
        bmcu_pkg::OP_PEEK: begin
          ram_re   = 1'b1;
          ram_addr = in_addr;
        end
        bmcu_pkg::OP_RESTART: begin
          pc_d     = '0;
          mbr_d    = '0;
          iobr_d   = '0;
          status_d = bmcu_pkg::ST_RUN;
        end
        bmcu_pkg::OP_EXEC: begin
          if (status_q == bmcu_pkg::ST_RUN) begin
            ram_re   = 1'b1;
            ram_addr = pc_q;
            pc_d     = pc_q + MemW'(1);
            state_d  = bmcu_pkg::S_FETCH_LO;
          end
        end
        default: begin
          state_d = bmcu_pkg::S_FIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bmcu_pkg::S_IDLE;
      status_q <= bmcu_pkg::ST_RUN;
      pc_q     <= '0;
      mbr_q    <= '0;
      iobr_q   <= '0;
      op_q     <= bmcu_pkg::OP_LOAD;
      rm_q     <= 1'b0;
      io_wr_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      pc_q     <= pc_d;
      mbr_q    <= mbr_d;
      iobr_q   <= iobr_d;
      op_q     <= op_d;
      rm_q     <= rm_d;
      io_wr_q  <= io_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q     <= hi_d;
    instr_q  <= instr_d;
    io_idx_q <= io_idx_d;
    io_val_q <= io_val_d;
  end

  // data memory, one port, registered read that holds when idle
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      mem[ram_addr] <= ram_wdata;
    end
    if (ram_re) begin
      ram_rdata_q <= mem[ram_addr];
    end
  end

  bmcu_out_slot u_out_slot (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[sv/bmcu_checker.sv]
// port-level checks for byte_machine_control_unit, attached by bind
// uses bmcu_pkg for item codes and widths
module bmcu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [bmcu_pkg::InTdataW-1:0]   s_axis_tdata,
  input logic [bmcu_pkg::InTuserW-1:0]   s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bmcu_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic in_acc;
  logic out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // restart reports cleared pc, status and registers
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser[1:0] == bmcu_pkg::OP_RESTART) ##1 out_free
    |=> m_axis_tvalid && m_axis_tdata[12:0] == 13'd0 && m_axis_tdata[44:29] == 16'd0)
    else $error("restart result wrong or late");

  // load reports no instruction, no io write and no peek byte
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser[1:0] == bmcu_pkg::OP_LOAD) ##1 out_free
    |=> m_axis_tvalid && m_axis_tdata[28:13] == 16'd0 && m_axis_tdata[45] == 1'b0
        && m_axis_tdata[66:51] == 16'd0)
    else $error("load result wrong or late");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid || !$past(rst_ni) && rst_ni)
    else $error("result valid out of reset");

  // unused input padding bits carry no meaning; ready stays high while no item is accepted and no result is pending
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc && !m_axis_tvalid && s_axis_tready |=> s_axis_tready)
    else $error("ready dropped with nothing in flight");

endmodule

bind byte_machine_control_unit bmcu_checker u_bmcu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
